// ----- hw/rtl/xt_keyboard_serial_transmitter_unit_macros.svh -----
// Assertion macros for the XT keyboard transmitter
`ifndef XT_KEYBOARD_SERIAL_TRANSMITTER_UNIT_MACROS_SVH
`define XT_KEYBOARD_SERIAL_TRANSMITTER_UNIT_MACROS_SVH

`ifndef SYNTH
`define XTKST_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xtkst assertion failed");
`define XTKST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xtkst assertion failed");
`else
`define XTKST_ASSERT_SAME(label, clk, rst, ante, cons)
`define XTKST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/xtkst_pkg.sv -----
// Types, constants and timing table of the XT keyboard transmitter
package xtkst_pkg;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned TICK_W     = 16;
   localparam int unsigned WAIT_W     = 6;

   localparam logic [1:0] CMD_TICK     = 2'd0;
   localparam logic [1:0] CMD_SEND     = 2'd1;
   localparam logic [1:0] CMD_SEND_EXT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_DATA  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_CLOCK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_GAP   = 2'd2;

   localparam logic [TICK_W-1:0] GAP_RESET   = 16'd4000;
   localparam logic [TICK_W-1:0] TICK_MAX    = 16'hFFFF;
   localparam logic [7:0]        PREFIX_BYTE = 8'hE0;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_START = 5'b00010,
      PH_BITS  = 5'b00100,
      PH_STOP  = 5'b01000,
      PH_GAP   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic                  fire;
      logic [1:0]            command;
      logic [7:0]            data_byte;
      logic [TICK_W-1:0]     prefix_gap;
   } step_req_type;

   typedef struct packed {
      logic clock_active;
      logic data_active;
      logic busy;
      logic rejected;
   } step_res_type;

   // ticks to wait before the next line change
   function automatic logic [WAIT_W-1:0] step_wait(phase_type ph, logic [1:0] step);
      logic [WAIT_W-1:0] w;
      if (ph == PH_START) begin
         if (step == 2'd0)      w = 6'd5;
         else if (step == 2'd1) w = 6'd50;
         else                   w = 6'd40;
      end else if (ph == PH_BITS) begin
         if (step == 2'd0)      w = 6'd15;
         else if (step == 2'd1) w = 6'd25;
         else                   w = 6'd40;
      end else begin
         w = step[0] ? 6'd5 : 6'd30;
      end
      return w;
   endfunction

endpackage

// ----- hw/rtl/xtkst_req_if.sv -----
// Command item channel
interface xtkst_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;

   modport source (output valid, command, data_byte, input ready);
   modport sink   (input valid, command, data_byte, output ready);
endinterface

// ----- hw/rtl/xtkst_rsp_if.sv -----
// Line state result item channel
interface xtkst_rsp_if;
   logic valid;
   logic ready;
   logic clock_pin;
   logic data_pin;
   logic busy_res;
   logic rejected;

   modport source (output valid, clock_pin, data_pin, busy_res, rejected, input ready);
   modport sink   (input valid, clock_pin, data_pin, busy_res, rejected, output ready);
endinterface

// ----- hw/rtl/xtkst_csr_if.sv -----
// Register write channel
interface xtkst_csr_if;
   import xtkst_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- hw/rtl/xtkst_frame_fsm.sv -----
// Frame sequencer: line state, timing counter and byte shifter
`include "xt_keyboard_serial_transmitter_unit_macros.svh"
module xtkst_frame_fsm (
   input  logic                   clock,
   input  logic                   reset,
   input  xtkst_pkg::step_req_type req,
   output xtkst_pkg::step_res_type res
);
   import xtkst_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [1:0]        step_ff, step_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [2:0]        bit_ff, bit_in;
   logic [7:0]        shift_ff, shift_in;
   logic [7:0]        held_ff, held_in;
   logic              pending_ff, pending_in;
   logic              clk_act_ff, clk_act_in;
   logic              dat_act_ff, dat_act_in;
   logic              rej;
   logic [TICK_W-1:0] tick_inc;
   logic [WAIT_W-1:0] wait_now;

   assign tick_inc = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + 16'd1;
   assign wait_now = step_wait(phase_ff, step_ff);

   always_comb begin
      phase_in   = phase_ff;
      step_in    = step_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      held_in    = held_ff;
      pending_in = pending_ff;
      clk_act_in = clk_act_ff;
      dat_act_in = dat_act_ff;
      rej        = 1'b0;
      if (req.fire) begin
         unique case (req.command)
            CMD_TICK: begin
               if (phase_ff == PH_GAP) begin
                  tick_in = tick_inc;
                  if (tick_inc >= req.prefix_gap) begin
                     pending_in = 1'b0;
                     shift_in   = held_ff;
                     phase_in   = PH_START;
                     step_in    = 2'd0;
                     tick_in    = '0;
                     bit_in     = 3'd0;
                     clk_act_in = 1'b1;
                  end
               end else if (phase_ff != PH_IDLE) begin
                  tick_in = tick_inc;
                  if (tick_inc >= {{(TICK_W-WAIT_W){1'b0}}, wait_now}) begin
                     tick_in = '0;
                     unique case (phase_ff)
                        PH_START: begin
                           if (step_ff == 2'd0) begin
                              dat_act_in = 1'b0;
                              step_in    = 2'd1;
                           end else if (step_ff == 2'd1) begin
                              clk_act_in = 1'b0;
                              step_in    = 2'd2;
                           end else begin
                              clk_act_in = 1'b1;
                              phase_in   = PH_BITS;
                              step_in    = 2'd0;
                              bit_in     = 3'd0;
                           end
                        end
                        PH_BITS: begin
                           if (step_ff == 2'd0) begin
                              dat_act_in = ~shift_ff[bit_ff];
                              step_in    = 2'd1;
                           end else if (step_ff == 2'd1) begin
                              clk_act_in = 1'b0;
                              step_in    = 2'd2;
                           end else begin
                              clk_act_in = 1'b1;
                              step_in    = 2'd0;
                              if (bit_ff == 3'd7) begin
                                 phase_in = PH_STOP;
                                 bit_in   = 3'd0;
                              end else begin
                                 bit_in = bit_ff + 3'd1;
                              end
                           end
                        end
                        default: begin
                           if (step_ff == 2'd0) begin
                              clk_act_in = 1'b0;
                              step_in    = 2'd1;
                           end else begin
                              dat_act_in = 1'b1;
                              step_in    = 2'd0;
                              if (!pending_ff) begin
                                 phase_in = PH_IDLE;
                              end else if (req.prefix_gap == '0) begin
                                 pending_in = 1'b0;
                                 shift_in   = held_ff;
                                 phase_in   = PH_START;
                                 bit_in     = 3'd0;
                                 clk_act_in = 1'b1;
                              end else begin
                                 phase_in = PH_GAP;
                              end
                           end
                        end
                     endcase
                  end
               end
            end
            CMD_SEND, CMD_SEND_EXT: begin
               if (phase_ff != PH_IDLE) begin
                  rej = 1'b1;
               end else begin
                  phase_in   = PH_START;
                  step_in    = 2'd0;
                  tick_in    = '0;
                  bit_in     = 3'd0;
                  clk_act_in = 1'b1;
                  if (req.command == CMD_SEND) begin
                     pending_in = 1'b0;
                     shift_in   = req.data_byte;
                  end else begin
                     pending_in = 1'b1;
                     held_in    = req.data_byte;
                     shift_in   = PREFIX_BYTE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign res.clock_active = clk_act_in;
   assign res.data_active  = dat_act_in;
   assign res.busy         = (phase_in != PH_IDLE);
   assign res.rejected     = rej;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         step_ff    <= 2'd0;
         tick_ff    <= '0;
         bit_ff     <= 3'd0;
         pending_ff <= 1'b0;
         clk_act_ff <= 1'b0;
         dat_act_ff <= 1'b1;
      end else begin
         phase_ff   <= phase_in;
         step_ff    <= step_in;
         tick_ff    <= tick_in;
         bit_ff     <= bit_in;
         pending_ff <= pending_in;
         clk_act_ff <= clk_act_in;
         dat_act_ff <= dat_act_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      held_ff  <= held_in;
   end

   `XTKST_ASSERT_SAME(a_rej_only_busy, clock, reset, rej, phase_ff != PH_IDLE)
   `XTKST_ASSERT_SAME(a_idle_clean, clock, reset, phase_ff == PH_IDLE,
      tick_ff == '0 && step_ff == 2'd0 && !pending_ff)
   `XTKST_ASSERT_SAME(a_step_range, clock, reset, 1'b1,
      step_ff != 2'd3 && (phase_ff != PH_STOP || step_ff != 2'd2))
   `XTKST_ASSERT_NEXT(a_send_starts, clock, reset,
      req.fire && phase_ff == PH_IDLE &&
      (req.command == CMD_SEND || req.command == CMD_SEND_EXT),
      phase_ff == PH_START && clk_act_ff)
   `XTKST_ASSERT_SAME(a_gap_pending, clock, reset, phase_ff == PH_GAP, pending_ff)

endmodule

// ----- hw/rtl/xt_keyboard_serial_transmitter_unit.sv -----
// Top level of the XT keyboard transmitter: item registers, registers, line polarity
// Each command item (a one-microsecond tick, a send or an extended send) yields one
// result item giving the clock and data line levels after that item, a busy flag and
// a flag for a send dropped because a frame or prefix gap was still running. One item
// is accepted per clock cycle while the result channel keeps up; each item passes
// through the input register, the frame sequencer and the result register.
// Registers are written through the csr channel, which is always ready; write them only
// while no items are in flight.
module xt_keyboard_serial_transmitter_unit (
   input logic       clock,
   input logic       reset,
   xtkst_req_if.sink   req_ch,
   xtkst_rsp_if.source rsp_ch,
   xtkst_csr_if.sink   csr_ch
);
   import xtkst_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [1:0]        cmd_ff;
   logic [7:0]        byte_ff;
   logic              out_valid_ff, out_valid_in;
   logic              clk_pin_ff, dat_pin_ff, busy_ff, rej_ff;
   logic              inv_data_ff, inv_clock_ff;
   logic [TICK_W-1:0] gap_ff;
   logic              advance;
   logic              req_take;
   step_req_type      step_req;
   step_res_type      step_res;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = (in_valid_ff && advance) ? 1'b1 :
                         (rsp_ch.ready ? 1'b0 : out_valid_ff);

   assign step_req.fire       = in_valid_ff && advance;
   assign step_req.command    = cmd_ff;
   assign step_req.data_byte  = byte_ff;
   assign step_req.prefix_gap = gap_ff;

   xtkst_frame_fsm u_fsm (
      .clock (clock),
      .reset (reset),
      .req   (step_req),
      .res   (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         inv_data_ff  <= 1'b0;
         inv_clock_ff <= 1'b0;
         gap_ff       <= GAP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               CSR_INVERT_DATA:  inv_data_ff  <= csr_ch.wdata[0];
               CSR_INVERT_CLOCK: inv_clock_ff <= csr_ch.wdata[0];
               CSR_PREFIX_GAP:   gap_ff       <= csr_ch.wdata[TICK_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff  <= req_ch.command;
         byte_ff <= req_ch.data_byte;
      end
      if (step_req.fire) begin
         clk_pin_ff <= ~(step_res.clock_active ^ inv_clock_ff);
         dat_pin_ff <= ~(step_res.data_active ^ inv_data_ff);
         busy_ff    <= step_res.busy;
         rej_ff     <= step_res.rejected;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.clock_pin = clk_pin_ff;
   assign rsp_ch.data_pin  = dat_pin_ff;
   assign rsp_ch.busy_res  = busy_ff;
   assign rsp_ch.rejected  = rej_ff;

endmodule
